FILE: src/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg: shared types, codes and constant helpers for the Hamming SEC codec.
// Holds the beat payload structs, the status codes and the elaboration-time
// functions that lay out the data and parity positions of a codeword.
// ----------------------------------------------------------------------------
package hsc_pkg;

    // Field widths of one beat.
    localparam int W_BITS = 63;
    localparam int W_LEN  = 6;
    localparam int W_STAT = 2;
    localparam int N_SYN  = 6;

    // Operation selector.
    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    // Result status codes.
    typedef enum logic [W_STAT-1:0] {
        ST_NONE   = 2'd0,
        ST_FIXED  = 2'd1,
        ST_BEYOND = 2'd2
    } t_status;

    // One input beat.
    typedef struct packed {
        logic              kind;
        logic [W_BITS-1:0] in_bits;
        logic [W_LEN-1:0]  in_length;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [W_BITS-1:0] out_bits;
        logic [W_LEN-1:0]  out_length;
        logic [W_LEN-1:0]  syndrome;
        t_status           status;
    } t_result;

    // True when position p is a power of two (a parity position).
    function automatic bit is_pow2(input int p);
        return (p != 0) && ((p & (p - 1)) == 0);
    endfunction

    // Number of parity positions at or below position p.
    function automatic int pow2_upto(input int p);
        int cnt;
        cnt = 0;
        for (int k = 1; k <= p; k++) begin
            if (is_pow2(k)) begin
                cnt++;
            end
        end
        return cnt;
    endfunction

    // Data index carried by the non-parity position p, counted from zero.
    function automatic int data_index(input int p);
        return p - pow2_upto(p) - 1;
    endfunction

    // Codeword length built from data_len data bits within max_len positions.
    function automatic int enc_code_len(input int data_len, input int max_len);
        int n;
        n = 0;
        for (int p = 1; p <= max_len; p++) begin
            if (!is_pow2(p) && data_index(p) < data_len) begin
                n = p;
            end
        end
        return n;
    endfunction

    // Number of data bits left after stripping the parity positions up to n.
    function automatic int dec_data_len(input int n);
        return n - pow2_upto(n);
    endfunction

    // Positions whose number has bit i set.
    function automatic logic [W_BITS-1:0] pos_mask(input int i);
        logic [W_BITS-1:0] m;
        m = '0;
        for (int p = 1; p <= W_BITS; p++) begin
            m[p-1] = ((p >> i) & 1) != 0;
        end
        return m;
    endfunction

    // Positions one through n.
    function automatic logic [W_BITS-1:0] low_mask(input int n);
        logic [W_BITS-1:0] m;
        m = '0;
        for (int p = 1; p <= W_BITS; p++) begin
            m[p-1] = (p <= n);
        end
        return m;
    endfunction

endpackage

FILE: src/hsc_in_if.sv
// ----------------------------------------------------------------------------
// hsc_in_if: input channel of the Hamming SEC codec.
// Carries valid, ready and one data word or codeword per beat.
// ----------------------------------------------------------------------------
interface hsc_in_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [hsc_pkg::W_BITS-1:0] in_bits;
    logic [hsc_pkg::W_LEN-1:0]  in_length;

    modport source (output valid, kind, in_bits, in_length, input ready);
    modport sink   (input valid, kind, in_bits, in_length, output ready);
endinterface

FILE: src/hsc_out_if.sv
// ----------------------------------------------------------------------------
// hsc_out_if: result channel of the Hamming SEC codec.
// Carries valid, ready and one codeword or corrected data word per beat.
// ----------------------------------------------------------------------------
interface hsc_out_if;
    logic                       valid;
    logic                       ready;
    logic [hsc_pkg::W_BITS-1:0] out_bits;
    logic [hsc_pkg::W_LEN-1:0]  out_length;
    logic [hsc_pkg::W_LEN-1:0]  syndrome;
    logic [hsc_pkg::W_STAT-1:0] status;

    modport source (output valid, out_bits, out_length, syndrome, status, input ready);
    modport sink   (input valid, out_bits, out_length, syndrome, status, output ready);
endinterface

FILE: src/hsc_datapath.sv
// ----------------------------------------------------------------------------
// hsc_datapath: encode and decode logic of the Hamming SEC codec.
// Fixed position wiring plus one XOR tree per parity bit; the encode side
// scatters data onto the codeword, the decode side checks, fixes and packs.
// ----------------------------------------------------------------------------
module hsc_datapath #(
    parameter int MAX_CODE_LEN = 63,
    parameter int PARITY_BITS  = 6
) (
    input  hsc_pkg::t_item   i_item,
    output hsc_pkg::t_result o_result
);

    localparam int NB = hsc_pkg::W_BITS;
    localparam int NL = hsc_pkg::W_LEN;
    // Data bits that fit in the widest codeword.
    localparam int N_DATA_ALL = hsc_pkg::data_index(NB) + 1;

    logic [NB-1:0]          w_in_mask;
    logic [NB-1:0]          w_data;
    logic [NB-1:0]          w_cw;
    logic [NB-1:0]          w_scatter;
    logic [NB-1:0]          w_par_word;
    logic [NB-1:0]          w_codeword;
    logic [NB-1:0]          w_flip;
    logic [NB-1:0]          w_fixed;
    logic [NB-1:0]          w_compact;
    logic [hsc_pkg::N_SYN-1:0] w_par;
    logic [hsc_pkg::N_SYN-1:0] w_syn;
    logic [NL-1:0]          w_n;
    logic [NL-1:0]          w_enc_len_tab [2**NL];
    logic [NL-1:0]          w_dec_len_tab [2**NL];
    hsc_pkg::t_status       w_status;

    // Length tables, worked out at elaboration.
    for (genvar k = 0; k < 2**NL; k++) begin : g_tab
        assign w_enc_len_tab[k] = NL'(hsc_pkg::enc_code_len(k, MAX_CODE_LEN));
        assign w_dec_len_tab[k] = NL'(hsc_pkg::dec_data_len(k));
    end

    // Drop bits at and above the given length; decode also stops at the
    // longest codeword.
    assign w_data = i_item.in_bits & w_in_mask;
    assign w_cw   = w_data & hsc_pkg::low_mask(MAX_CODE_LEN);
    assign w_n    = (i_item.in_length > NL'(MAX_CODE_LEN)) ? NL'(MAX_CODE_LEN)
                                                           : i_item.in_length;

    // Per-position wiring: length mask, data scatter and flip select.
    for (genvar p = 1; p <= NB; p++) begin : g_pos
        localparam bit IS_P2 = hsc_pkg::is_pow2(p);
        localparam int DIDX  = hsc_pkg::data_index(p);

        assign w_in_mask[p-1] = (NL'(p) <= i_item.in_length);
        assign w_flip[p-1]    = (w_status == hsc_pkg::ST_FIXED) && (w_syn == NL'(p));

        if (IS_P2 || p > MAX_CODE_LEN) begin : g_nodata
            assign w_scatter[p-1] = 1'b0;
        end else begin : g_data
            assign w_scatter[p-1] = w_data[DIDX];
        end

        if (!IS_P2) begin : g_pack
            assign w_compact[DIDX] = w_fixed[p-1];
        end
    end

    // Packed data bits above the widest data word stay clear.
    for (genvar j = N_DATA_ALL; j < NB; j++) begin : g_pack_hi
        assign w_compact[j] = 1'b0;
    end

    // Parity and syndrome trees; checks beyond the configured count read zero.
    for (genvar i = 0; i < hsc_pkg::N_SYN; i++) begin : g_chk
        if (i < PARITY_BITS) begin : g_on
            assign w_par[i] = ^(w_scatter & hsc_pkg::pos_mask(i));
            assign w_syn[i] = ^(w_cw & hsc_pkg::pos_mask(i));
        end else begin : g_off
            assign w_par[i] = 1'b0;
            assign w_syn[i] = 1'b0;
        end
    end

    // Place the parity bits on their power-of-two positions.
    always_comb begin
        w_par_word = '0;
        for (int i = 0; i < hsc_pkg::N_SYN; i++) begin
            w_par_word[(1 << i) - 1] = w_par[i];
        end
    end

    assign w_codeword = w_scatter | w_par_word;

    // Classify the syndrome.
    always_comb begin
        if (w_syn == '0) begin
            w_status = hsc_pkg::ST_NONE;
        end else if (w_syn > w_n) begin
            w_status = hsc_pkg::ST_BEYOND;
        end else begin
            w_status = hsc_pkg::ST_FIXED;
        end
    end

    assign w_fixed = w_cw ^ w_flip;

    // Select the result for the operation.
    always_comb begin
        if (i_item.kind == hsc_pkg::KIND_ENCODE) begin
            o_result.out_bits   = w_codeword;
            o_result.out_length = w_enc_len_tab[i_item.in_length];
            o_result.syndrome   = '0;
            o_result.status     = hsc_pkg::ST_NONE;
        end else begin
            o_result.out_bits   = w_compact;
            o_result.out_length = w_dec_len_tab[w_n];
            o_result.syndrome   = w_syn;
            o_result.status     = w_status;
        end
    end

endmodule

FILE: src/hamming_sec_codec_core.sv
// ----------------------------------------------------------------------------
// hamming_sec_codec_core: variable-length Hamming single-error-correcting codec.
// Each beat carries a word of up to 63 bits (bit 0 is position 1), its length
// and an encode or decode selector. Encode lays the data on the positions that
// are not powers of two and fills in the parity bits; decode computes the
// syndrome, flips the named bit when it lies inside the word, reports a
// syndrome beyond the length, and strips the parity positions. A beat is taken
// into an input register, worked by one pass of position wiring and XOR trees,
// and held in a result register. One beat is accepted every cycle while results
// are taken; while a finished result waits to be taken, a new beat can still
// enter the input register if that is empty. No state is kept between beats.
// ----------------------------------------------------------------------------
module hamming_sec_codec_core #(
    parameter int MAX_CODE_LEN = 63,
    parameter int PARITY_BITS  = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hsc_in_if.sink           i_in,
    hsc_out_if.source        o_out
);

    logic             r_s1_valid;
    hsc_pkg::t_item   r_s1_item;
    logic             r_out_valid;
    hsc_pkg::t_result r_out;
    hsc_pkg::t_result w_result;
    logic             w_s1_go;
    logic             w_in_fire;

    // Stage one moves on when the result register is free or being emptied.
    assign w_s1_go    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_s1_go;
    assign w_in_fire  = i_in.valid && i_in.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
        if (w_in_fire) begin
            r_s1_item.kind      <= i_in.kind;
            r_s1_item.in_bits   <= i_in.in_bits;
            r_s1_item.in_length <= i_in.in_length;
        end
    end

    hsc_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .PARITY_BITS  (PARITY_BITS)
    ) u_datapath (
        .i_item   (r_s1_item),
        .o_result (w_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go) begin
            r_out_valid <= r_s1_valid;
        end
        if (w_s1_go && r_s1_valid) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_bits   = r_out.out_bits;
    assign o_out.out_length = r_out.out_length;
    assign o_out.syndrome   = r_out.syndrome;
    assign o_out.status     = r_out.status;

`ifndef SYNTHESIS
    // An accepted beat is always in stage one on the next cycle.
    a_fire_to_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> r_s1_valid)
        else $error("accepted beat did not reach stage one");

    // A stage-one beat that moves on shows up as a result.
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s1_go) |=> r_out_valid)
        else $error("stage-one beat lost on its way to the result register");

    // With the result register empty the input is never stalled.
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while the result register is empty");

    // A fix or an out-of-range report always comes with a nonzero syndrome.
    a_syn_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.status == hsc_pkg::ST_FIXED
                         || r_out.status == hsc_pkg::ST_BEYOND))
        |-> (r_out.syndrome != '0))
        else $error("error status reported with a zero syndrome");
`endif

endmodule
